// File: rtl/assert_macros.svh
// Assertion macros shared by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/cld_pkg.sv
// Package for the content-length deframer: widths, codes, result type.
`default_nettype none
package cld_pkg;

  localparam int LENGTH_BITS       = 24;
  localparam int HEADER_COUNT_BITS = 16;
  localparam int LVAL_W            = LENGTH_BITS + 1;
  localparam int MAXLEN_W          = 24;
  localparam int HLIMIT_W          = 16;
  localparam int CFG_DATA_W        = 24;
  localparam int LCMP_W = (LVAL_W > MAXLEN_W) ? LVAL_W : MAXLEN_W;
  localparam int HCMP_W = (HEADER_COUNT_BITS > HLIMIT_W) ? HEADER_COUNT_BITS : HLIMIT_W;

  localparam logic [MAXLEN_W-1:0] MAXLEN_RESET = 24'd1048576;
  localparam logic [HLIMIT_W-1:0] HLIMIT_RESET = 16'd8192;

  // register indexes
  localparam logic REG_MAX_BODY  = 1'b0;
  localparam logic REG_HDR_LIMIT = 1'b1;

  // phase
  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_BODY   = 1'b1;

  // terminator progress
  localparam logic [1:0] TERM_NONE  = 2'd0;
  localparam logic [1:0] TERM_CR    = 2'd1;
  localparam logic [1:0] TERM_CRLF  = 2'd2;
  localparam logic [1:0] TERM_CRLFCR = 2'd3;

  // value mode
  localparam logic [1:0] VM_IDLE   = 2'd0;
  localparam logic [1:0] VM_BLANKS = 2'd1;
  localparam logic [1:0] VM_DIGITS = 2'd2;
  localparam logic [1:0] VM_DONE   = 2'd3;

  // length status
  localparam logic [1:0] LS_NONE     = 2'd0;
  localparam logic [1:0] LS_FOUND    = 2'd1;
  localparam logic [1:0] LS_NODIGITS = 2'd2;

  // result kind and error codes
  localparam logic       KIND_BODY  = 1'b0;
  localparam logic       KIND_ERROR = 1'b1;
  localparam logic [1:0] ERR_NO_LENGTH  = 2'd0;
  localparam logic [1:0] ERR_BAD_LENGTH = 2'd1;
  localparam logic [1:0] ERR_HDR_LONG   = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [4:0] KEY_LEN  = 5'd15;
  localparam logic [4:0] COL_MAX  = 5'd31;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] code;
  } res_t;

  // lower-case "content-length:"
  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// File: rtl/content_length_frame_deframer.sv
// Top level of the content-length message deframer.
// Takes one stream byte per cycle and sustains one byte per cycle while
// out_stall is low. A byte passes an input register, then the header parser
// and body counter, then the result register. Header bytes give no result
// unless the header fails (missing/bad length, zero or oversize length,
// header over the limit), which gives one error beat; body bytes each give
// one body beat, the last one marked. While a result beat waits under
// out_stall, every byte waits too: the input register takes at most one
// more byte, then in_stall rises.
`default_nettype none
`include "assert_macros.svh"
module content_length_frame_deframer
  import cld_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_result_kind,
  output logic [7:0]                 out_body_byte,
  output logic                       out_last_of_body,
  output logic [1:0]                 out_error_code
);

  logic [MAXLEN_W-1:0] max_body_r;
  logic [HLIMIT_W-1:0] hlimit_r;
  logic                advance;
  logic                step;
  logic [7:0]          step_byte;
  logic                res_valid;
  res_t                res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r <= MAXLEN_RESET;
      hlimit_r   <= HLIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MAX_BODY:  max_body_r <= cfg_wdata[MAXLEN_W-1:0];
        REG_HDR_LIMIT: hlimit_r   <= cfg_wdata[HLIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cld_in_reg u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .advance   (advance),
    .step      (step),
    .step_byte (step_byte)
  );

  cld_frame_fsm u_fsm (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .step_byte       (step_byte),
    .max_body_length (max_body_r),
    .header_limit    (hlimit_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  cld_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (step),
    .res_valid        (res_valid),
    .res              (res),
    .advance          (advance),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_body_byte    (out_body_byte),
    .out_last_of_body (out_last_of_body),
    .out_error_code   (out_error_code)
  );

  `ASSERT_IMPL(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with result side free")

endmodule
`default_nettype wire

// File: rtl/cld_in_reg.sv
// Input register stage of the deframer.
`default_nettype none
module cld_in_reg
  import cld_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       advance,
  output logic            step,
  output logic [7:0]      step_byte
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_stall  = valid_r && !advance;
  assign step      = valid_r && advance;
  assign step_byte = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule
`default_nettype wire

// File: rtl/cld_frame_fsm.sv
// Header parser and body counter: per-byte state update of the deframer.
`default_nettype none
`include "assert_macros.svh"
module cld_frame_fsm
  import cld_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          step_byte,
  input  wire logic [MAXLEN_W-1:0] max_body_length,
  input  wire logic [HLIMIT_W-1:0] header_limit,
  output logic                     res_valid,
  output res_t                     res
);

  logic                         phase_r, phase_nxt;
  logic [1:0]                   term_r, term_nxt;
  logic [4:0]                   col_r, col_nxt;
  logic                         match_r, match_nxt;
  logic [1:0]                   vmode_r, vmode_nxt;
  logic [1:0]                   lstat_r, lstat_nxt;
  logic [LVAL_W-1:0]            lval_r, lval_nxt;
  logic [HEADER_COUNT_BITS-1:0] hcnt_r, hcnt_nxt;
  logic [LENGTH_BITS-1:0]       rem_r, rem_nxt;

  logic [HEADER_COUNT_BITS-1:0] hcnt_inc;
  logic [LENGTH_BITS-1:0]       rem_dec;
  logic [LVAL_W+3:0]            prod;
  logic [7:0]                   low;
  logic [3:0]                   digit;
  logic                         is_digit;
  logic                         is_blank;
  logic                         line_byte;
  logic                         too_big;
  logic                         hdr_over;

  assign is_digit = (step_byte >= "0") && (step_byte <= "9");
  assign is_blank = (step_byte == CH_SPACE) || (step_byte == CH_TAB);
  assign digit    = 4'(step_byte - "0");
  assign low      = ((step_byte >= "A") && (step_byte <= "Z")) ? step_byte + 8'd32 : step_byte;
  assign prod     = (LVAL_W+4)'({lval_r, 3'b000}) + (LVAL_W+4)'({lval_r, 1'b0}) +
                    (LVAL_W+4)'(digit);
  assign hcnt_inc = (&hcnt_r) ? hcnt_r : hcnt_r + 1'b1;
  assign rem_dec  = (rem_r != '0) ? rem_r - 1'b1 : rem_r;
  assign too_big  = lval_r[LVAL_W-1] ||
                    (LCMP_W'(lval_r) > LCMP_W'(max_body_length));
  assign hdr_over = (HCMP_W'(hcnt_inc) >= HCMP_W'(header_limit)) || (&hcnt_inc);

  always_comb begin
    phase_nxt = phase_r;
    term_nxt  = term_r;
    col_nxt   = col_r;
    match_nxt = match_r;
    vmode_nxt = vmode_r;
    lstat_nxt = lstat_r;
    lval_nxt  = lval_r;
    hcnt_nxt  = hcnt_r;
    rem_nxt   = rem_r;
    line_byte = 1'b0;
    res_valid = 1'b0;
    res       = '{kind: KIND_BODY, data: 8'h00, last: 1'b0, code: ERR_NO_LENGTH};

    if (step) begin
      if (phase_r == PH_BODY) begin
        rem_nxt   = rem_dec;
        res_valid = 1'b1;
        res.data  = step_byte;
        res.last  = (rem_dec == '0);
        if (rem_dec == '0) begin
          phase_nxt = PH_HEADER;
        end
      end else begin
        hcnt_nxt = hcnt_inc;
        if ((step_byte == CH_LF) && (term_r == TERM_CRLFCR)) begin
          phase_nxt = PH_HEADER;
          term_nxt  = TERM_NONE;
          col_nxt   = '0;
          match_nxt = 1'b1;
          vmode_nxt = VM_IDLE;
          lstat_nxt = LS_NONE;
          lval_nxt  = '0;
          hcnt_nxt  = '0;
          if (lstat_r != LS_FOUND) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_NO_LENGTH;
          end else if ((lval_r == '0) || too_big) begin
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_BAD_LENGTH;
          end else begin
            phase_nxt = PH_BODY;
            rem_nxt   = lval_r[LENGTH_BITS-1:0];
          end
        end else begin
          if (step_byte == CH_CR) begin
            term_nxt  = (term_r == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
            line_byte = 1'b1;
          end else if ((step_byte == CH_LF) && (term_r == TERM_CR)) begin
            term_nxt  = TERM_CRLF;
            col_nxt   = '0;
            match_nxt = 1'b1;
            vmode_nxt = VM_IDLE;
          end else begin
            term_nxt  = TERM_NONE;
            line_byte = 1'b1;
          end

          if (line_byte) begin
            unique case (vmode_r)
              VM_BLANKS: begin
                if (is_blank) begin
                  vmode_nxt = VM_BLANKS;
                end else if (is_digit) begin
                  vmode_nxt = VM_DIGITS;
                  lval_nxt  = LVAL_W'(digit);
                end else begin
                  vmode_nxt = VM_DONE;
                  lstat_nxt = LS_NODIGITS;
                end
              end
              VM_DIGITS: begin
                if (is_digit) begin
                  lval_nxt = (prod[LVAL_W+3:LVAL_W] != '0) ? '1 : prod[LVAL_W-1:0];
                end else begin
                  vmode_nxt = VM_DONE;
                  lstat_nxt = LS_FOUND;
                end
              end
              VM_IDLE: begin
                if (col_r < KEY_LEN) begin
                  if (low != key_char(col_r[3:0])) begin
                    match_nxt = 1'b0;
                  end else if (match_r && (col_r == KEY_LEN - 5'd1) &&
                               (lstat_r == LS_NONE)) begin
                    vmode_nxt = VM_BLANKS;
                  end
                end
              end
              VM_DONE: begin
              end
              default: begin
              end
            endcase
            if (col_r != COL_MAX) begin
              col_nxt = col_r + 5'd1;
            end
          end

          if (hdr_over) begin
            phase_nxt = PH_HEADER;
            term_nxt  = TERM_NONE;
            col_nxt   = '0;
            match_nxt = 1'b1;
            vmode_nxt = VM_IDLE;
            lstat_nxt = LS_NONE;
            lval_nxt  = '0;
            hcnt_nxt  = '0;
            res_valid = 1'b1;
            res.kind  = KIND_ERROR;
            res.code  = ERR_HDR_LONG;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      term_r  <= TERM_NONE;
      col_r   <= '0;
      match_r <= 1'b1;
      vmode_r <= VM_IDLE;
      lstat_r <= LS_NONE;
      lval_r  <= '0;
      hcnt_r  <= '0;
      rem_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      term_r  <= term_nxt;
      col_r   <= col_nxt;
      match_r <= match_nxt;
      vmode_r <= vmode_nxt;
      lstat_r <= lstat_nxt;
      lval_r  <= lval_nxt;
      hcnt_r  <= hcnt_nxt;
      rem_r   <= rem_nxt;
    end
  end

  `ASSERT_IMPL(a_body_nonzero, phase_r == PH_BODY, rem_r != '0, "body phase with zero count")
  `ASSERT_IMPL(a_body_beat, step && (phase_r == PH_BODY), res_valid && (res.kind == KIND_BODY), "body beat lost")
  `ASSERT_NEXT(a_err_hunts, step && res_valid && (res.kind == KIND_ERROR), (phase_r == PH_HEADER) && (hcnt_r == '0), "error did not restart header")

endmodule
`default_nettype wire

// File: rtl/cld_out_reg.sv
// Result register stage of the deframer.
`default_nettype none
module cld_out_reg
  import cld_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  step,
  input  wire logic  res_valid,
  input  wire res_t  res,
  output logic       advance,
  output logic       out_valid,
  input  wire logic  out_stall,
  output logic       out_result_kind,
  output logic [7:0] out_body_byte,
  output logic       out_last_of_body,
  output logic [1:0] out_error_code
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_result_kind  = res_r.kind;
  assign out_body_byte    = res_r.data;
  assign out_last_of_body = res_r.last;
  assign out_error_code   = res_r.code;

endmodule
`default_nettype wire
